### design/cholesky_factor_packed_unit_defines.svh
// Assertion helpers used by the checker.
`ifndef CHOLESKY_FACTOR_PACKED_UNIT_DEFINES_SVH
`define CHOLESKY_FACTOR_PACKED_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define CFPU_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cfpu checker: property failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define CFPU_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cfpu checker: property failed");

`endif

### design/cfpu_pkg.sv
`timescale 1ns / 1ps
package cfpu_pkg;

	localparam int MAX_ORDER_DEF = 8;
	localparam int ACC_W         = 52;
	localparam int SQ_STEPS      = 24;
	localparam int RC_STEPS      = 33;
	localparam logic [3:0] SIZE_RESET = 4'd8;

	// datapath operations
	localparam logic [4:0] OP_IDLE   = 5'd0;
	localparam logic [4:0] OP_LOAD   = 5'd1;
	localparam logic [4:0] OP_ELEM   = 5'd2;
	localparam logic [4:0] OP_CAPA   = 5'd3;
	localparam logic [4:0] OP_MUL    = 5'd4;
	localparam logic [4:0] OP_OFFMUL = 5'd5;
	localparam logic [4:0] OP_RND    = 5'd6;
	localparam logic [4:0] OP_ACC    = 5'd7;
	localparam logic [4:0] OP_DIFF   = 5'd8;
	localparam logic [4:0] OP_SQINIT = 5'd9;
	localparam logic [4:0] OP_SQSTEP = 5'd10;
	localparam logic [4:0] OP_SQWR   = 5'd11;
	localparam logic [4:0] OP_RCSTEP = 5'd12;
	localparam logic [4:0] OP_RCWR   = 5'd13;
	localparam logic [4:0] OP_OFFWR  = 5'd14;
	localparam logic [4:0] OP_EMIT   = 5'd15;
	localparam logic [4:0] OP_FAIL   = 5'd16;

	typedef struct packed {
		logic signed [31:0] element_value;
		logic [2:0]         row_index;
		logic [2:0]         col_index;
		logic               load_last;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] factor_value;
		logic [2:0]         out_row;
		logic [2:0]         out_col;
		logic               run_last;
		logic               positive_definite;
	} out_item_t;

	typedef struct packed {
		logic [4:0] op;
		logic [2:0] row;
		logic [2:0] col;
		logic       last;
	} cmd_t;

	typedef struct packed {
		logic s_positive;
		logic unit_done;
	} status_t;

	// packed upper-triangle position of (r, c)
	function automatic logic [7:0] pos(input logic [3:0] r, input logic [3:0] c);
		logic [7:0] cc;
		cc = {4'd0, c};
		return 8'((cc * (cc + 8'd1)) >> 1) + {4'd0, r};
	endfunction

	// clamp to the signed 32-bit range
	function automatic logic signed [31:0] sat32(input logic signed [52:0] v);
		if (v > $signed({21'd0, 32'h7FFF_FFFF})) return 32'sh7FFF_FFFF;
		if (v < $signed({21'h1F_FFFF, 32'h8000_0000})) return 32'sh8000_0000;
		return v[31:0];
	endfunction

	function automatic logic [31:0] mag(input logic signed [31:0] v);
		return v[31] ? 32'(-v) : 32'(v);
	endfunction

endpackage

### design/cfpu_ram.sv
`timescale 1ns / 1ps
module cfpu_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 36,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, registered read port
	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end

endmodule

### design/cfpu_ctrl.sv
`timescale 1ns / 1ps
module cfpu_ctrl #(
	parameter int MAX_ORDER = cfpu_pkg::MAX_ORDER_DEF,
	localparam int DEPTH = MAX_ORDER * (MAX_ORDER + 1) / 2,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int IW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [3:0]        cfg_wdata,
	input  logic              in_valid,
	input  logic              in_load_last,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	output cfpu_pkg::cmd_t    cmd,
	input  cfpu_pkg::status_t status,
	output logic [AW-1:0]     in_raddr,
	output logic [AW-1:0]     f_raddr,
	output logic [AW-1:0]     f_waddr,
	output logic [IW-1:0]     piv_idx
);
	import cfpu_pkg::*;

	localparam logic [4:0] ST_LOAD   = 5'd0;
	localparam logic [4:0] ST_ENTRY  = 5'd1;
	localparam logic [4:0] ST_ELEM   = 5'd2;
	localparam logic [4:0] ST_RDA    = 5'd3;
	localparam logic [4:0] ST_RDB    = 5'd4;
	localparam logic [4:0] ST_MUL    = 5'd5;
	localparam logic [4:0] ST_RND    = 5'd6;
	localparam logic [4:0] ST_ACC    = 5'd7;
	localparam logic [4:0] ST_DIFF   = 5'd8;
	localparam logic [4:0] ST_PIV    = 5'd9;
	localparam logic [4:0] ST_SQ     = 5'd10;
	localparam logic [4:0] ST_SQWR   = 5'd11;
	localparam logic [4:0] ST_RC     = 5'd12;
	localparam logic [4:0] ST_RCWR   = 5'd13;
	localparam logic [4:0] ST_OFFMUL = 5'd14;
	localparam logic [4:0] ST_OFFRND = 5'd15;
	localparam logic [4:0] ST_OFFWR  = 5'd16;
	localparam logic [4:0] ST_NEXT   = 5'd17;
	localparam logic [4:0] ST_EREAD  = 5'd18;
	localparam logic [4:0] ST_ELOAD  = 5'd19;
	localparam logic [4:0] ST_EOUT   = 5'd20;
	localparam logic [4:0] ST_FOUT   = 5'd21;

	logic [4:0]    state_q, state_d;
	logic [3:0]    size_q;
	logic [IW-1:0] i_q, j_q, k_q, ei_q, ej_q;
	logic [AW-1:0] ep_q;
	logic          out_valid_q;

	logic [3:0] n_eff, nm1;
	logic       i_last, j_is_i, k_done, e_last;

	// effective order, clamped to 1..MAX_ORDER
	always_comb begin
		if (size_q == 4'd0) n_eff = 4'd1;
		else if (int'(size_q) > MAX_ORDER) n_eff = 4'(MAX_ORDER);
		else n_eff = size_q;
		nm1 = n_eff - 4'd1;
	end

	assign i_last = (4'(i_q) == nm1);
	assign j_is_i = (j_q == i_q);
	assign k_done = ((4'(k_q) + 4'd1) == 4'(j_q));
	assign e_last = (4'(ei_q) == nm1) && (ej_q == ei_q);

	assign in_stall  = (state_q != ST_LOAD);
	assign out_valid = out_valid_q;

	// next state and datapath command
	always_comb begin
		state_d  = state_q;
		cmd      = '{op: OP_IDLE, row: 3'(ej_q), col: 3'(ei_q), last: e_last};
		in_raddr = AW'(pos(4'(j_q), 4'(i_q)));
		f_raddr  = ep_q;
		f_waddr  = AW'(pos(4'(j_q), 4'(i_q)));
		piv_idx  = j_q;
		unique case (state_q)
			ST_LOAD: begin
				if (in_valid) begin
					cmd.op = OP_LOAD;
					if (in_load_last) state_d = ST_ENTRY;
				end
			end
			ST_ENTRY: state_d = ST_ELEM;
			ST_ELEM: begin
				cmd.op  = OP_ELEM;
				state_d = (j_q != '0) ? ST_RDA : ST_DIFF;
			end
			ST_RDA: begin
				f_raddr = AW'(pos(4'(k_q), 4'(i_q)));
				state_d = ST_RDB;
			end
			ST_RDB: begin
				cmd.op  = OP_CAPA;
				f_raddr = AW'(pos(4'(k_q), 4'(j_q)));
				state_d = ST_MUL;
			end
			ST_MUL: begin
				cmd.op  = OP_MUL;
				state_d = ST_RND;
			end
			ST_RND: begin
				cmd.op  = OP_RND;
				state_d = ST_ACC;
			end
			ST_ACC: begin
				cmd.op  = OP_ACC;
				state_d = k_done ? ST_DIFF : ST_RDA;
			end
			ST_DIFF: begin
				cmd.op  = OP_DIFF;
				state_d = j_is_i ? ST_PIV : ST_OFFMUL;
			end
			ST_PIV: begin
				if (status.s_positive) begin
					cmd.op  = OP_SQINIT;
					state_d = ST_SQ;
				end else begin
					cmd.op   = OP_FAIL;
					cmd.row  = 3'(i_q);
					cmd.col  = 3'(i_q);
					cmd.last = 1'b1;
					state_d  = ST_FOUT;
				end
			end
			ST_SQ: begin
				cmd.op = OP_SQSTEP;
				if (status.unit_done) state_d = ST_SQWR;
			end
			ST_SQWR: begin
				cmd.op  = OP_SQWR;
				f_waddr = AW'(pos(4'(i_q), 4'(i_q)));
				state_d = ST_RC;
			end
			ST_RC: begin
				cmd.op = OP_RCSTEP;
				if (status.unit_done) state_d = ST_RCWR;
			end
			ST_RCWR: begin
				cmd.op  = OP_RCWR;
				piv_idx = i_q;
				state_d = ST_NEXT;
			end
			ST_OFFMUL: begin
				cmd.op  = OP_OFFMUL;
				state_d = ST_OFFRND;
			end
			ST_OFFRND: begin
				cmd.op  = OP_RND;
				state_d = ST_OFFWR;
			end
			ST_OFFWR: begin
				cmd.op  = OP_OFFWR;
				state_d = ST_NEXT;
			end
			ST_NEXT: begin
				if (j_is_i && i_last) state_d = ST_EREAD;
				else state_d = ST_ENTRY;
			end
			ST_EREAD: state_d = ST_ELOAD;
			ST_ELOAD: begin
				cmd.op  = OP_EMIT;
				state_d = ST_EOUT;
			end
			ST_EOUT: begin
				if (!out_stall) state_d = e_last ? ST_LOAD : ST_EREAD;
			end
			ST_FOUT: begin
				if (!out_stall) state_d = ST_LOAD;
			end
			default: state_d = ST_LOAD;
		endcase
	end

	// state, counters and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			size_q      <= SIZE_RESET;
			i_q         <= '0;
			j_q         <= '0;
			k_q         <= '0;
			ei_q        <= '0;
			ej_q        <= '0;
			ep_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) size_q <= cfg_wdata;
			unique case (state_q)
				ST_LOAD: begin
					i_q <= '0;
					j_q <= '0;
				end
				ST_ELEM: k_q <= '0;
				ST_ACC: k_q <= k_q + IW'(1);
				ST_PIV: begin
					if (!status.s_positive) out_valid_q <= 1'b1;
				end
				ST_NEXT: begin
					if (j_is_i) begin
						i_q <= i_q + IW'(1);
						j_q <= '0;
					end else begin
						j_q <= j_q + IW'(1);
					end
					ei_q <= '0;
					ej_q <= '0;
					ep_q <= '0;
				end
				ST_ELOAD: out_valid_q <= 1'b1;
				ST_EOUT: begin
					if (!out_stall) begin
						out_valid_q <= 1'b0;
						ep_q        <= ep_q + AW'(1);
						if (ej_q == ei_q) begin
							ei_q <= ei_q + IW'(1);
							ej_q <= '0;
						end else begin
							ej_q <= ej_q + IW'(1);
						end
					end
				end
				ST_FOUT: begin
					if (!out_stall) out_valid_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end

endmodule

### design/cfpu_datapath.sv
`timescale 1ns / 1ps
module cfpu_datapath #(
	parameter int MAX_ORDER = cfpu_pkg::MAX_ORDER_DEF,
	localparam int DEPTH = MAX_ORDER * (MAX_ORDER + 1) / 2,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int IW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cfpu_pkg::cmd_t      cmd,
	input  cfpu_pkg::in_item_t  in_data,
	input  logic [AW-1:0]       in_raddr,
	input  logic [AW-1:0]       f_raddr,
	input  logic [AW-1:0]       f_waddr,
	input  logic [IW-1:0]       piv_idx,
	output cfpu_pkg::status_t   status,
	output cfpu_pkg::out_item_t out_data
);
	import cfpu_pkg::*;

	logic [2:0]    ld_row, ld_col;
	logic          ld_we;
	logic [AW-1:0] ld_addr;
	logic [31:0]   in_rdata, f_rdata, f_wdata;
	logic          f_we;

	logic signed [31:0]      elem_q, fa_q, s_q;
	logic signed [ACC_W-1:0] acc_q;
	logic [63:0]             prod_s1;
	logic                    neg_s1;
	logic signed [48:0]      rnd_s2;
	logic [47:0]             sx_q, sres_q, sbit_q;
	logic [32:0]             num_q;
	logic [24:0]             rem_q;
	logic [23:0]             div_q;
	logic [5:0]              it_q;
	logic                    mode_q;
	logic [31:0]             recip_q [MAX_ORDER];
	out_item_t               out_q;

	logic signed [31:0] mul_a, mul_b;
	logic [63:0]        rsum;
	logic [47:0]        rmag, sq_t;
	logic [24:0]        rc_r2;
	logic signed [52:0] diff;
	logic signed [31:0] off_val;

	// load tags, mirrored into the upper triangle
	always_comb begin
		if (in_data.row_index > in_data.col_index) begin
			ld_row = in_data.col_index;
			ld_col = in_data.row_index;
		end else begin
			ld_row = in_data.row_index;
			ld_col = in_data.col_index;
		end
		ld_we   = (cmd.op == OP_LOAD) && (int'(ld_col) < MAX_ORDER);
		ld_addr = AW'(pos({1'b0, ld_row}, {1'b0, ld_col}));
	end

	cfpu_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_in_ram (
		.clk  (clk),
		.we   (ld_we),
		.waddr(ld_addr),
		.wdata(in_data.element_value),
		.raddr(in_raddr),
		.rdata(in_rdata)
	);

	// factor store: root on a pivot, scaled difference elsewhere
	assign off_val = sat32({{4{rnd_s2[48]}}, rnd_s2});
	assign f_we    = (cmd.op == OP_SQWR) || (cmd.op == OP_OFFWR);
	assign f_wdata = (cmd.op == OP_SQWR) ? {8'd0, sres_q[23:0]} : off_val;

	cfpu_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_f_ram (
		.clk  (clk),
		.we   (f_we),
		.waddr(f_waddr),
		.wdata(f_wdata),
		.raddr(f_raddr),
		.rdata(f_rdata)
	);

	// arithmetic helpers
	always_comb begin
		if (cmd.op == OP_OFFMUL) begin
			mul_a = recip_q[piv_idx];
			mul_b = s_q;
		end else begin
			mul_a = fa_q;
			mul_b = f_rdata;
		end
		rsum  = prod_s1 + 64'h8000;
		rmag  = rsum[63:16];
		diff  = {{21{elem_q[31]}}, elem_q} - {{(53 - ACC_W){acc_q[ACC_W-1]}}, acc_q};
		sq_t  = sres_q + sbit_q;
		rc_r2 = {rem_q[23:0], num_q[32]};
	end

	assign status.s_positive = !s_q[31] && (s_q != 32'sd0);
	assign status.unit_done  = mode_q ? (it_q == 6'(RC_STEPS - 1))
	                                  : (it_q == 6'(SQ_STEPS - 1));

	// iteration control of the root and reciprocal units
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			it_q   <= '0;
			mode_q <= 1'b0;
		end else begin
			case (cmd.op)
				OP_SQINIT: begin
					it_q   <= '0;
					mode_q <= 1'b0;
				end
				OP_SQWR: begin
					it_q   <= '0;
					mode_q <= 1'b1;
				end
				OP_SQSTEP, OP_RCSTEP: it_q <= it_q + 6'd1;
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_ELEM: begin
				elem_q <= in_rdata;
				acc_q  <= '0;
			end
			OP_CAPA: fa_q <= f_rdata;
			OP_MUL, OP_OFFMUL: begin
				prod_s1 <= {32'd0, mag(mul_a)} * {32'd0, mag(mul_b)};
				neg_s1  <= mul_a[31] ^ mul_b[31];
			end
			OP_RND: rnd_s2 <= neg_s1 ? -$signed({1'b0, rmag}) : $signed({1'b0, rmag});
			OP_ACC: acc_q <= acc_q + {{(ACC_W - 49){rnd_s2[48]}}, rnd_s2};
			OP_DIFF: s_q <= sat32(diff);
			OP_SQINIT: begin
				sx_q   <= {s_q, 16'd0};
				sres_q <= '0;
				sbit_q <= 48'd1 << 46;
			end
			OP_SQSTEP: begin
				if (sx_q >= sq_t) begin
					sx_q   <= sx_q - sq_t;
					sres_q <= (sres_q >> 1) + sbit_q;
				end else begin
					sres_q <= sres_q >> 1;
				end
				sbit_q <= sbit_q >> 2;
			end
			OP_SQWR: begin
				num_q <= 33'h1_0000_0000 + {10'd0, sres_q[23:1]};
				rem_q <= '0;
				div_q <= sres_q[23:0];
			end
			OP_RCSTEP: begin
				// restoring division, one quotient bit per step
				if (rc_r2 >= {1'b0, div_q}) begin
					rem_q <= rc_r2 - {1'b0, div_q};
					num_q <= {num_q[31:0], 1'b1};
				end else begin
					rem_q <= rc_r2;
					num_q <= {num_q[31:0], 1'b0};
				end
			end
			OP_RCWR: recip_q[piv_idx] <= (num_q > 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF
			                                                       : num_q[31:0];
			OP_EMIT: out_q <= '{factor_value: f_rdata, out_row: cmd.row,
			                    out_col: cmd.col, run_last: cmd.last,
			                    positive_definite: 1'b1};
			OP_FAIL: out_q <= '{factor_value: 32'sd0, out_row: cmd.row,
			                    out_col: cmd.col, run_last: 1'b1,
			                    positive_definite: 1'b0};
			default: ;
		endcase
	end

	assign out_data = out_q;

endmodule

### design/cholesky_factor_packed_unit.sv
`timescale 1ns / 1ps
// channel | direction | handshake           | payload
// --------+-----------+---------------------+-----------------------------
// in      | input     | in_valid / in_stall | in_data  (matrix entry, tags)
// out     | output    | out_valid/out_stall | out_data (factor entry)
// cfg     | input     | cfg_we              | cfg_wdata (matrix_size)
//
// Loading takes one entry per cycle. After the last entry the input stalls while
// the controller walks the triangle: an off-diagonal entry runs a dot product
// over a shared 32x32 multiplier and a factor RAM with one write and one read port,
// a pivot the same, then a 24-step square root and a 33-step reciprocal divider.
// Each result then passes a registered RAM read and the output register.
// Reset clears control only; no clearing pass. A stalled result holds in place.
module cholesky_factor_packed_unit #(
	parameter int MAX_ORDER = cfpu_pkg::MAX_ORDER_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [3:0]          cfg_wdata,
	input  logic                in_valid,
	output logic                in_stall,
	input  cfpu_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output cfpu_pkg::out_item_t out_data
);
	import cfpu_pkg::*;

	localparam int DEPTH = MAX_ORDER * (MAX_ORDER + 1) / 2;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int IW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;

	cmd_t          cmd;
	status_t       status;
	logic [AW-1:0] in_raddr, f_raddr, f_waddr;
	logic [IW-1:0] piv_idx;

	cfpu_ctrl #(.MAX_ORDER(MAX_ORDER)) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_load_last(in_data.load_last),
		.in_stall    (in_stall),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.cmd         (cmd),
		.status      (status),
		.in_raddr    (in_raddr),
		.f_raddr     (f_raddr),
		.f_waddr     (f_waddr),
		.piv_idx     (piv_idx)
	);

	cfpu_datapath #(.MAX_ORDER(MAX_ORDER)) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.in_data (in_data),
		.in_raddr(in_raddr),
		.f_raddr (f_raddr),
		.f_waddr (f_waddr),
		.piv_idx (piv_idx),
		.status  (status),
		.out_data(out_data)
	);

endmodule

### design/cfpu_checker.sv
`timescale 1ns / 1ps
`include "cholesky_factor_packed_unit_defines.svh"
module cfpu_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_stall,
	input cfpu_pkg::in_item_t  in_data,
	input logic                out_valid,
	input logic                out_stall,
	input cfpu_pkg::out_item_t out_data
);

	// a stalled result stays offered and unchanged
	`CFPU_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid)
	`CFPU_ASSERT_NXT(a_out_stable, out_valid && out_stall, $stable(out_data))
	// input is only taken while no result is pending
	`CFPU_ASSERT_IMP(a_in_excl, !in_stall, !out_valid)
	// the closing entry starts a run, so the input stalls right after it
	`CFPU_ASSERT_NXT(a_run_start, in_valid && !in_stall && in_data.load_last, in_stall)
	// a failure is a single zero result that ends the run
	`CFPU_ASSERT_IMP(a_fail_form, out_valid && !out_data.positive_definite,
		out_data.run_last && (out_data.factor_value == 32'sd0))

endmodule

bind cholesky_factor_packed_unit cfpu_checker u_cfpu_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_stall (in_stall),
	.in_data  (in_data),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.out_data (out_data)
);
